@@ hdl/imm_pkg.sv @@
// Shared constants, register map and helpers for the integer matrix multiply unit.
// Depends on nothing; used by integer_matrix_multiply_unit.
package imm_pkg;

    localparam int MAX_DIM   = 8;
    localparam int DIM_W     = $clog2(MAX_DIM + 1);
    localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(2 * DEPTH + 1);
    localparam int ELEM_W    = 16;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int ACC_W     = 35;
    localparam int REG_W     = 4;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int OUT_IDX_W = 3;

    localparam logic [1:0] REG_ROWS_A    = 2'd0;
    localparam logic [1:0] REG_INNER_DIM = 2'd1;
    localparam logic [1:0] REG_COLS_B    = 2'd2;

    localparam logic [REG_W-1:0] DIM_RESET = REG_W'(MAX_DIM);

    function automatic logic [DIM_W-1:0] eff_dim(input logic [REG_W-1:0] v);
        logic [DIM_W-1:0] r;
        priority if (v == '0) begin
            r = DIM_W'(1);
        end else if (32'(v) > MAX_DIM) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

endpackage

@@ hdl/integer_matrix_multiply_unit.sv @@
// Top level of the integer matrix multiply unit: APB registers, element stores and
// a sequencer around one shared multiply-accumulate pipeline. Uses imm_pkg.
//
// Elements of A (row-major, rows_a x inner_dim) then B (row-major, inner_dim x
// cols_b) are taken one per cycle while the unit is loading. The transfer of the
// last element of B starts the product: the unit stalls its input and walks every
// product element in row-major order through a single 16x16 multiplier and a
// 35-bit accumulator. Each product element takes one store read per term, then the
// multiply, accumulate and output-register stages; the result is held back while the
// output is stalled. Dimensions of 0 act as 1 and values above 8 act as 8.
// Any register write restarts the load from the first element of A.
module integer_matrix_multiply_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [imm_pkg::PADDR_W-1:0]            paddr,
    input  logic [imm_pkg::PDATA_W-1:0]            pwdata,
    output logic [imm_pkg::PDATA_W-1:0]            prdata,
    output logic                                   pready,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [imm_pkg::ELEM_W-1:0]      i_element,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [imm_pkg::OUT_IDX_W-1:0]          o_row_index,
    output logic [imm_pkg::OUT_IDX_W-1:0]          o_col_index,
    output logic signed [imm_pkg::ACC_W-1:0]       o_product_value,
    output logic                                   o_last_result
);

    typedef enum logic [1:0] {
        S_LOAD,
        S_MAC,
        S_DRAIN,
        S_WAIT
    } t_state;

    t_state                               r_state;
    logic [imm_pkg::REG_W-1:0]            r_rows_a;
    logic [imm_pkg::REG_W-1:0]            r_inner_dim;
    logic [imm_pkg::REG_W-1:0]            r_cols_b;
    logic [imm_pkg::CNT_W-1:0]            r_load_count;

    logic [imm_pkg::IDX_W-1:0]            r_i;
    logic [imm_pkg::IDX_W-1:0]            r_j;
    logic [imm_pkg::IDX_W-1:0]            r_k;
    logic [imm_pkg::ADDR_W-1:0]           r_a_base;
    logic [imm_pkg::ADDR_W-1:0]           r_a_addr;
    logic [imm_pkg::ADDR_W-1:0]           r_b_addr;

    logic signed [imm_pkg::ELEM_W-1:0]    r_mem_a [imm_pkg::DEPTH];
    logic signed [imm_pkg::ELEM_W-1:0]    r_mem_b [imm_pkg::DEPTH];
    logic signed [imm_pkg::ELEM_W-1:0]    r_a_q;
    logic signed [imm_pkg::ELEM_W-1:0]    r_b_q;
    logic signed [imm_pkg::PROD_W-1:0]    r_prod;
    logic signed [imm_pkg::ACC_W-1:0]     r_acc;
    logic                                 r_v1;
    logic                                 r_l1;
    logic                                 r_f1;
    logic                                 r_v2;
    logic                                 r_l2;
    logic                                 r_f2;

    logic                                 r_out_vld;
    logic [imm_pkg::OUT_IDX_W-1:0]        r_row;
    logic [imm_pkg::OUT_IDX_W-1:0]        r_col;
    logic signed [imm_pkg::ACC_W-1:0]     r_val;
    logic                                 r_last;

    logic [imm_pkg::DIM_W-1:0]            ra;
    logic [imm_pkg::DIM_W-1:0]            kd;
    logic [imm_pkg::DIM_W-1:0]            cb;
    logic [imm_pkg::CNT_W-1:0]            na;
    logic [imm_pkg::CNT_W-1:0]            nb;
    logic [imm_pkg::CNT_W-1:0]            n_load_count;
    logic [imm_pkg::CNT_W-1:0]            b_offset;
    logic                                 cfg_wr;
    logic                                 in_fire;
    logic                                 load_in_a;
    logic                                 load_done;
    logic                                 k_last;
    logic                                 j_last;
    logic                                 i_last;
    logic                                 out_free;
    logic [imm_pkg::IDX_W-1:0]            n_i;
    logic [imm_pkg::IDX_W-1:0]            n_j;
    logic [imm_pkg::ADDR_W-1:0]           n_a_base;

    assign ra = imm_pkg::eff_dim(r_rows_a);
    assign kd = imm_pkg::eff_dim(r_inner_dim);
    assign cb = imm_pkg::eff_dim(r_cols_b);
    assign na = imm_pkg::CNT_W'(ra) * imm_pkg::CNT_W'(kd);
    assign nb = imm_pkg::CNT_W'(kd) * imm_pkg::CNT_W'(cb);

    assign cfg_wr       = psel && penable && pwrite && pready;
    assign in_fire      = i_valid && !o_stall;
    assign load_in_a    = r_load_count < na;
    assign b_offset     = r_load_count - na;
    assign n_load_count = r_load_count + imm_pkg::CNT_W'(1);
    assign load_done    = n_load_count == (na + nb);

    assign k_last   = {1'b0, r_k} == (kd - imm_pkg::DIM_W'(1));
    assign j_last   = {1'b0, r_j} == (cb - imm_pkg::DIM_W'(1));
    assign i_last   = {1'b0, r_i} == (ra - imm_pkg::DIM_W'(1));
    assign out_free = !r_out_vld || !i_stall;

    always_comb begin
        n_i      = r_i;
        n_j      = r_j + imm_pkg::IDX_W'(1);
        n_a_base = r_a_base;
        if (j_last) begin
            n_j      = '0;
            n_i      = r_i + imm_pkg::IDX_W'(1);
            n_a_base = r_a_base + imm_pkg::ADDR_W'(kd);
        end
    end

    assign pready  = 1'b1;
    assign o_stall = r_state != S_LOAD;

    always_comb begin
        unique case (paddr[3:2])
            imm_pkg::REG_ROWS_A:    prdata = imm_pkg::PDATA_W'(r_rows_a);
            imm_pkg::REG_INNER_DIM: prdata = imm_pkg::PDATA_W'(r_inner_dim);
            imm_pkg::REG_COLS_B:    prdata = imm_pkg::PDATA_W'(r_cols_b);
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && load_in_a) begin
            r_mem_a[r_load_count[imm_pkg::ADDR_W-1:0]] <= i_element;
        end
        if (in_fire && !load_in_a) begin
            r_mem_b[b_offset[imm_pkg::ADDR_W-1:0]] <= i_element;
        end
        r_a_q <= r_mem_a[r_a_addr];
        r_b_q <= r_mem_b[r_b_addr];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_a_q * r_b_q;
        if (r_v2) begin
            r_acc <= (r_f2 ? imm_pkg::ACC_W'(0) : r_acc)
                   + imm_pkg::ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_l1 <= 1'b0;
            r_f1 <= 1'b0;
            r_v2 <= 1'b0;
            r_l2 <= 1'b0;
            r_f2 <= 1'b0;
        end else begin
            r_v1 <= r_state == S_MAC;
            r_l1 <= k_last;
            r_f1 <= r_k == '0;
            r_v2 <= r_v1;
            r_l2 <= r_l1;
            r_f2 <= r_f1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_rows_a     <= imm_pkg::DIM_RESET;
            r_inner_dim  <= imm_pkg::DIM_RESET;
            r_cols_b     <= imm_pkg::DIM_RESET;
            r_load_count <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_k          <= '0;
            r_a_base     <= '0;
            r_a_addr     <= '0;
            r_b_addr     <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            if (r_out_vld && !i_stall && r_state != S_WAIT) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (in_fire && load_done) begin
                        r_load_count <= '0;
                        r_i          <= '0;
                        r_j          <= '0;
                        r_k          <= '0;
                        r_a_base     <= '0;
                        r_a_addr     <= '0;
                        r_b_addr     <= '0;
                        r_state      <= S_MAC;
                    end else if (cfg_wr) begin
                        r_load_count <= '0;
                    end else if (in_fire) begin
                        r_load_count <= n_load_count;
                    end
                end
                S_MAC: begin
                    if (k_last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_k      <= r_k + imm_pkg::IDX_W'(1);
                        r_a_addr <= r_a_addr + imm_pkg::ADDR_W'(1);
                        r_b_addr <= r_b_addr + imm_pkg::ADDR_W'(cb);
                    end
                end
                S_DRAIN: begin
                    if (r_v2 && r_l2) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (out_free) begin
                        r_out_vld <= 1'b1;
                        r_row     <= imm_pkg::OUT_IDX_W'(r_i);
                        r_col     <= imm_pkg::OUT_IDX_W'(r_j);
                        r_val     <= r_acc;
                        r_last    <= i_last && j_last;
                        r_k       <= '0;
                        if (i_last && j_last) begin
                            r_i      <= '0;
                            r_j      <= '0;
                            r_a_base <= '0;
                            r_state  <= S_LOAD;
                        end else begin
                            r_i      <= n_i;
                            r_j      <= n_j;
                            r_a_base <= n_a_base;
                            r_a_addr <= n_a_base;
                            r_b_addr <= imm_pkg::ADDR_W'(n_j);
                            r_state  <= S_MAC;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    imm_pkg::REG_ROWS_A:    r_rows_a    <= pwdata[imm_pkg::REG_W-1:0];
                    imm_pkg::REG_INNER_DIM: r_inner_dim <= pwdata[imm_pkg::REG_W-1:0];
                    imm_pkg::REG_COLS_B:    r_cols_b    <= pwdata[imm_pkg::REG_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_valid         = r_out_vld;
    assign o_row_index     = r_row;
    assign o_col_index     = r_col;
    assign o_product_value = r_val;
    assign o_last_result   = r_last;

endmodule

@@ verif/integer_matrix_multiply_unit_tb.sv @@
// Self-checking testbench for integer_matrix_multiply_unit: directed table, then random runs.
// Drives the APB port and both stream channels and predicts every product element itself.
// Depends on imm_pkg and the integer_matrix_multiply_unit RTL only.
module integer_matrix_multiply_unit_tb;

    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int ITEMS_TARGET  = 330;
    localparam int SETTLE_CYCLES = imm_pkg::MAX_DIM + 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int IDLE_PCT      = 23;

    typedef enum logic [1:0] {STEP_WRITE, STEP_READ, STEP_ELEM} t_step_kind;

    typedef struct packed {
        t_step_kind                       kind;
        logic [1:0]                       idx;
        logic [31:0]                      data;
        logic                             checked;
        logic signed [imm_pkg::ACC_W-1:0] want;
    } t_plan_step;

    typedef struct packed {
        logic [imm_pkg::OUT_IDX_W-1:0]    row;
        logic [imm_pkg::OUT_IDX_W-1:0]    col;
        logic signed [imm_pkg::ACC_W-1:0] value;
        logic                             last;
    } t_product;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n;
    logic                                 psel;
    logic                                 penable;
    logic                                 pwrite;
    logic [imm_pkg::PADDR_W-1:0]          paddr;
    logic [imm_pkg::PDATA_W-1:0]          pwdata;
    logic [imm_pkg::PDATA_W-1:0]          prdata;
    logic                                 pready;
    logic                                 i_valid;
    logic                                 o_stall;
    logic signed [imm_pkg::ELEM_W-1:0]    i_element;
    logic                                 o_valid;
    logic                                 i_stall;
    logic [imm_pkg::OUT_IDX_W-1:0]        o_row_index;
    logic [imm_pkg::OUT_IDX_W-1:0]        o_col_index;
    logic signed [imm_pkg::ACC_W-1:0]     o_product_value;
    logic                                 o_last_result;

    logic [imm_pkg::REG_W-1:0]            dim_rows;
    logic [imm_pkg::REG_W-1:0]            dim_inner;
    logic [imm_pkg::REG_W-1:0]            dim_cols;
    logic signed [imm_pkg::ELEM_W-1:0]    mat_a [imm_pkg::DEPTH];
    logic signed [imm_pkg::ELEM_W-1:0]    mat_b [imm_pkg::DEPTH];
    int                                   load_pos;

    t_product                             pending_products [$];
    t_plan_step                           plan [$];
    int                                   failures;
    int                                   items_sent;
    int                                   cycles;
    bit                                   calm;
    bit                                   hold_req;

    integer_matrix_multiply_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_element       (i_element),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_row_index     (o_row_index),
        .o_col_index     (o_col_index),
        .o_product_value (o_product_value),
        .o_last_result   (o_last_result)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int used_dim(input logic [imm_pkg::REG_W-1:0] v);
        if (v == '0) begin
            return 1;
        end
        if (int'(v) > imm_pkg::MAX_DIM) begin
            return imm_pkg::MAX_DIM;
        end
        return int'(v);
    endfunction

    function automatic void load_and_multiply(input logic signed [imm_pkg::ELEM_W-1:0] e);
        int ra, kd, cb, na, nb, i, j, k;
        longint acc;
        t_product item;
        ra = used_dim(dim_rows);
        kd = used_dim(dim_inner);
        cb = used_dim(dim_cols);
        na = ra * kd;
        nb = kd * cb;
        if (load_pos >= na + nb) begin
            load_pos = 0;
        end
        if (load_pos < na) begin
            mat_a[load_pos % imm_pkg::DEPTH] = e;
        end else begin
            mat_b[(load_pos - na) % imm_pkg::DEPTH] = e;
        end
        load_pos++;
        if (load_pos < na + nb) begin
            return;
        end
        load_pos = 0;
        for (i = 0; i < ra; i++) begin
            for (j = 0; j < cb; j++) begin
                acc = 0;
                for (k = 0; k < kd; k++) begin
                    acc += longint'(mat_a[(i * kd + k) % imm_pkg::DEPTH])
                         * longint'(mat_b[(k * cb + j) % imm_pkg::DEPTH]);
                end
                item.row   = imm_pkg::OUT_IDX_W'(i);
                item.col   = imm_pkg::OUT_IDX_W'(j);
                item.value = acc[imm_pkg::ACC_W-1:0];
                item.last  = (i == ra - 1) && (j == cb - 1);
                pending_products.push_back(item);
            end
        end
    endfunction

    function automatic void add_step(input t_step_kind kind, input logic [1:0] idx,
                                     input int data, input bit checked, input longint want);
        t_plan_step s;
        s.kind    = kind;
        s.idx     = idx;
        s.data    = data;
        s.checked = checked;
        s.want    = want[imm_pkg::ACC_W-1:0];
        plan.push_back(s);
    endfunction

    function automatic logic [imm_pkg::ELEM_W-1:0] random_element();
        logic [imm_pkg::ELEM_W-1:0] corner [5];
        corner = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
        if ($urandom_range(0, 9) == 0) begin
            return corner[$urandom_range(0, 4)];
        end
        return imm_pkg::ELEM_W'($urandom());
    endfunction

    function automatic int pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            return 0;
        end else if (r < 12) begin
            return $urandom_range(imm_pkg::MAX_DIM + 1, 15);
        end else if (r < 16) begin
            return imm_pkg::MAX_DIM;
        end
        return $urandom_range(1, 4);
    endfunction

    task automatic send_element(input logic [imm_pkg::ELEM_W-1:0] e);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_element = e;
        @(posedge i_clk);
        while (o_stall !== 1'b0) begin
            @(posedge i_clk);
        end
        items_sent++;
        load_and_multiply(e);
    endtask

    // drop the input and wait until every predicted product has arrived
    task automatic settle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_products.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [imm_pkg::PDATA_W-1:0] data);
        @(negedge i_clk);
        i_valid = 1'b0;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = imm_pkg::PADDR_W'({idx, 2'b00});
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        unique case (idx)
            imm_pkg::REG_ROWS_A:    dim_rows  = data[imm_pkg::REG_W-1:0];
            imm_pkg::REG_INNER_DIM: dim_inner = data[imm_pkg::REG_W-1:0];
            imm_pkg::REG_COLS_B:    dim_cols  = data[imm_pkg::REG_W-1:0];
            default: ;
        endcase
        load_pos = 0;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic reg_read(input logic [1:0] idx,
                            output logic [imm_pkg::PDATA_W-1:0] value);
        @(negedge i_clk);
        i_valid = 1'b0;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = imm_pkg::PADDR_W'({idx, 2'b00});
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        value = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic run_phase(input int r, input int k, input int c, input int runs,
                             input bit extreme);
        int na, cb, total, cut, p;
        settle();
        reg_write(imm_pkg::REG_ROWS_A, {28'($urandom()), 4'(r)});
        reg_write(imm_pkg::REG_INNER_DIM, {28'($urandom()), 4'(k)});
        reg_write(imm_pkg::REG_COLS_B, {28'($urandom()), 4'(c)});
        if ($urandom_range(0, 4) == 0) begin
            reg_write(REG_SPARE, $urandom());
        end
        na    = used_dim(4'(r)) * used_dim(4'(k));
        cb    = used_dim(4'(c));
        total = na + used_dim(4'(k)) * cb;
        // abandon a partial load now and then
        if (total > 1 && $urandom_range(0, 4) == 0) begin
            cut = $urandom_range(1, total - 1);
            repeat (cut) send_element(random_element());
            settle();
            if ($urandom_range(0, 1) == 1) begin
                reg_write(REG_SPARE, $urandom());
            end else begin
                reg_write(imm_pkg::REG_COLS_B, {28'($urandom()), 4'(c)});
            end
        end
        repeat (runs) begin
            for (p = 0; p < total; p++) begin
                if (!extreme) begin
                    send_element(random_element());
                end else if (p < na || ((p - na) % cb) % 2 == 0) begin
                    send_element(16'h8000);
                end else begin
                    send_element(16'h7fff);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : check_products
        t_product want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_products.size() == 0) begin
                $display("%0t: unexpected product row %0d col %0d value %0d", $time,
                         o_row_index, o_col_index, o_product_value);
                failures++;
            end else begin
                want = pending_products.pop_front();
                if (o_row_index !== want.row) begin
                    $display("%0t: row index expected %0d got %0d", $time,
                             want.row, o_row_index);
                    failures++;
                end
                if (o_col_index !== want.col) begin
                    $display("%0t: col index expected %0d got %0d", $time,
                             want.col, o_col_index);
                    failures++;
                end
                if (o_product_value !== want.value) begin
                    $display("%0t: product value expected %0d got %0d", $time,
                             $signed(want.value), o_product_value);
                    failures++;
                end
                if (o_last_result !== want.last) begin
                    $display("%0t: last flag expected %0b got %0b", $time,
                             want.last, o_last_result);
                    failures++;
                end
            end
        end
    end

    initial begin
        int held;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                // hold the output off while the sender keeps offering
                for (held = 0; held < HOLD_CYCLES; held++) begin
                    i_stall = 1'b1;
                    @(negedge i_clk);
                end
            end
            i_stall = !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("integer_matrix_multiply_unit: mismatch");
                $finish;
            end
        end
    end

    initial begin
        logic [imm_pkg::PDATA_W-1:0] readback;
        i_rst_n   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        i_valid   = 1'b0;
        i_element = '0;
        dim_rows  = imm_pkg::DIM_RESET;
        dim_inner = imm_pkg::DIM_RESET;
        dim_cols  = imm_pkg::DIM_RESET;
        load_pos  = 0;
        failures  = 0;
        items_sent = 0;
        calm      = 1'b0;
        hold_req  = 1'b0;
        foreach (mat_a[n]) begin
            mat_a[n] = '0;
            mat_b[n] = '0;
        end
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // registers after reset
        add_step(STEP_READ,  imm_pkg::REG_ROWS_A,    0, 1, 8);
        add_step(STEP_READ,  imm_pkg::REG_INNER_DIM, 0, 1, 8);
        add_step(STEP_READ,  imm_pkg::REG_COLS_B,    0, 1, 8);
        // 1x1x1 products at the element extremes
        add_step(STEP_WRITE, imm_pkg::REG_ROWS_A,    1, 0, 0);
        add_step(STEP_WRITE, imm_pkg::REG_INNER_DIM, 1, 0, 0);
        add_step(STEP_WRITE, imm_pkg::REG_COLS_B,    1, 0, 0);
        add_step(STEP_ELEM,  imm_pkg::REG_ROWS_A, -32768, 0, 0);
        add_step(STEP_ELEM,  imm_pkg::REG_ROWS_A, -32768, 1, 1073741824);
        add_step(STEP_ELEM,  imm_pkg::REG_ROWS_A,  32767, 0, 0);
        add_step(STEP_ELEM,  imm_pkg::REG_ROWS_A, -32768, 1, -1073709056);
        add_step(STEP_ELEM,  imm_pkg::REG_ROWS_A,  32767, 0, 0);
        add_step(STEP_ELEM,  imm_pkg::REG_ROWS_A,  32767, 1, 1073676289);
        // zero dimensions act as one
        add_step(STEP_WRITE, imm_pkg::REG_ROWS_A,    0, 0, 0);
        add_step(STEP_WRITE, imm_pkg::REG_INNER_DIM, 0, 0, 0);
        add_step(STEP_WRITE, imm_pkg::REG_COLS_B,    0, 0, 0);
        add_step(STEP_READ,  imm_pkg::REG_ROWS_A,    0, 1, 0);
        add_step(STEP_ELEM,  imm_pkg::REG_ROWS_A,  3, 0, 0);
        add_step(STEP_ELEM,  imm_pkg::REG_ROWS_A, -5, 1, -15);
        // write past the register list abandons the load and changes nothing
        add_step(STEP_ELEM,  imm_pkg::REG_ROWS_A,  7, 0, 0);
        add_step(STEP_WRITE, REG_SPARE,            5, 0, 0);
        add_step(STEP_READ,  imm_pkg::REG_ROWS_A,  0, 1, 0);
        add_step(STEP_ELEM,  imm_pkg::REG_ROWS_A,  2, 0, 0);
        add_step(STEP_ELEM,  imm_pkg::REG_ROWS_A,  9, 1, 18);
        // real register write in the middle of a load
        add_step(STEP_ELEM,  imm_pkg::REG_ROWS_A, 11, 0, 0);
        add_step(STEP_WRITE, imm_pkg::REG_COLS_B,  0, 0, 0);
        add_step(STEP_ELEM,  imm_pkg::REG_ROWS_A, -1, 0, 0);
        add_step(STEP_ELEM,  imm_pkg::REG_ROWS_A, -1, 1, 1);
        // oversized dimension acts as the maximum: 8x1x1
        add_step(STEP_WRITE, imm_pkg::REG_ROWS_A,  9, 0, 0);
        add_step(STEP_READ,  imm_pkg::REG_ROWS_A,  0, 1, 9);
        add_step(STEP_ELEM,  imm_pkg::REG_ROWS_A,  1, 0, 0);
        add_step(STEP_ELEM,  imm_pkg::REG_ROWS_A, -1, 0, 0);
        add_step(STEP_ELEM,  imm_pkg::REG_ROWS_A,  32767, 0, 0);
        add_step(STEP_ELEM,  imm_pkg::REG_ROWS_A, -32768, 0, 0);
        add_step(STEP_ELEM,  imm_pkg::REG_ROWS_A,  0, 0, 0);
        add_step(STEP_ELEM,  imm_pkg::REG_ROWS_A,  2, 0, 0);
        add_step(STEP_ELEM,  imm_pkg::REG_ROWS_A,  100, 0, 0);
        add_step(STEP_ELEM,  imm_pkg::REG_ROWS_A, -100, 0, 0);
        add_step(STEP_ELEM,  imm_pkg::REG_ROWS_A, -32768, 0, 0);

        foreach (plan[n]) begin
            unique case (plan[n].kind)
                STEP_WRITE: begin
                    settle();
                    reg_write(plan[n].idx, plan[n].data);
                end
                STEP_READ: begin
                    settle();
                    reg_read(plan[n].idx, readback);
                    if (plan[n].checked
                        && readback !== plan[n].want[imm_pkg::PDATA_W-1:0]) begin
                        $display("%0t: register %0d read expected %0d got %0d", $time,
                                 plan[n].idx, plan[n].want[imm_pkg::PDATA_W-1:0],
                                 readback);
                        failures++;
                    end
                end
                default: begin
                    send_element(plan[n].data[imm_pkg::ELEM_W-1:0]);
                    if (plan[n].checked) begin
                        pending_products[$].value = plan[n].want;
                    end
                end
            endcase
        end

        // full size with the widest sums of both signs
        run_phase(15, 12, imm_pkg::MAX_DIM, 1, 1'b1);
        hold_req = 1'b1;
        run_phase(2, 2, 2, 4, 1'b0);
        calm = 1'b1;
        run_phase(3, 3, 3, 3, 1'b0);
        calm = 1'b0;
        while (items_sent < ITEMS_TARGET) begin
            run_phase(pick_dim(), pick_dim(), pick_dim(), $urandom_range(1, 3), 1'b0);
        end
        settle();

        if (failures == 0) begin
            $display("integer_matrix_multiply_unit: match");
        end else begin
            $display("integer_matrix_multiply_unit: mismatch");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/imm_pkg.sv
hdl/integer_matrix_multiply_unit.sv
verif/integer_matrix_multiply_unit_tb.sv
